[sv/cttc_pkg.sv]
// ---------------------------------------------------------------------------
// cttc_pkg: shared types, constants and functions of the telegram tag check
// AES-128 S-box, round helpers, sequencer states and the channel payloads.
// ---------------------------------------------------------------------------
package cttc_pkg;

    localparam logic [7:0] B0_FLAG  = 8'h49;
    localparam logic [7:0] A0_FLAG  = 8'h01;
    localparam logic [7:0] LEN_MIN  = 8'd11;
    localparam logic [7:0] LEN_MAX  = 8'd33;
    localparam logic [7:0] LEN_B2   = 8'd17;
    localparam logic [3:0] LAST_RND = 4'd10;

    typedef struct packed {
        logic [47:0] sender_address;
        logic [63:0] key_low;
        logic [63:0] key_high;
        logic [31:0] sequence_counter;
        logic [31:0] last_counter;
        logic [7:0]  telegram_length;
        logic [7:0]  adv_type;
        logic [15:0] maker_id;
        logic [63:0] data_word0;
        logic [63:0] data_word1;
        logic [47:0] data_word2;
        logic [31:0] signature;
    } t_in_item;

    typedef struct packed {
        logic        accepted;
        logic        tag_ok;
        logic        counter_newer;
        logic        length_error;
        logic [31:0] computed_tag;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE, ST_B0, ST_B1, ST_B2, ST_A0, ST_DONE
    } t_state;

    // Control between sequencer and round unit.
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } t_aes_ctl;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[x];
    endfunction

    function automatic logic [7:0] gf_dbl(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte i of a block lives in bits 8*i+7 : 8*i.
    function automatic logic [7:0] byte_at(input logic [127:0] b, input int i);
        return b[8*i +: 8];
    endfunction

endpackage

[sv/cttc_stream_if.sv]
// ---------------------------------------------------------------------------
// cttc_stream_if: valid/ready channel
// Carries one payload of a given type; a transfer happens when both are high.
// ---------------------------------------------------------------------------
interface cttc_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[sv/cttc_aes_round.sv]
// ---------------------------------------------------------------------------
// cttc_aes_round: iterative AES-128 encryption unit
// One round and one key expansion step per cycle.
// ---------------------------------------------------------------------------
module cttc_aes_round
    import cttc_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [127:0]   i_key,
    input  logic [127:0]   i_block,
    output logic           o_busy,
    output logic           o_done,
    output logic [127:0]   o_result
);

    logic [127:0] r_state, n_state;
    logic [127:0] r_rkey, n_rkey;
    logic [7:0]   r_rc, n_rc;
    logic [3:0]   r_rnd, n_rnd;
    logic         r_busy, n_busy;
    logic         r_done, n_done;
    logic [127:0] w_sub, w_mix, w_key;

    // SubBytes and ShiftRows of the current state.
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                w_sub[8*(c*4+r) +: 8] = sbox(byte_at(r_state, ((c + r) & 3) * 4 + r));
            end
        end
    end

    // MixColumns, skipped in the last round.
    always_comb begin
        logic [7:0] a0, a1, a2, a3, al;
        w_mix = w_sub;
        for (int c = 0; c < 4; c++) begin
            a0 = w_sub[32*c +: 8];
            a1 = w_sub[32*c+8 +: 8];
            a2 = w_sub[32*c+16 +: 8];
            a3 = w_sub[32*c+24 +: 8];
            al = a0 ^ a1 ^ a2 ^ a3;
            if (r_rnd != LAST_RND) begin
                w_mix[32*c +: 8]    = a0 ^ al ^ gf_dbl(a0 ^ a1);
                w_mix[32*c+8 +: 8]  = a1 ^ al ^ gf_dbl(a1 ^ a2);
                w_mix[32*c+16 +: 8] = a2 ^ al ^ gf_dbl(a2 ^ a3);
                w_mix[32*c+24 +: 8] = a3 ^ al ^ gf_dbl(a3 ^ a0);
            end
        end
    end

    // Next round key.
    always_comb begin
        w_key[7:0]   = r_rkey[7:0]   ^ sbox(r_rkey[111:104]) ^ r_rc;
        w_key[15:8]  = r_rkey[15:8]  ^ sbox(r_rkey[119:112]);
        w_key[23:16] = r_rkey[23:16] ^ sbox(r_rkey[127:120]);
        w_key[31:24] = r_rkey[31:24] ^ sbox(r_rkey[103:96]);
        for (int i = 4; i < 16; i++) begin
            w_key[8*i +: 8] = r_rkey[8*i +: 8] ^ w_key[8*(i-4) +: 8];
        end
    end

    // Round sequencing.
    always_comb begin
        n_state = r_state;
        n_rkey  = r_rkey;
        n_rc    = r_rc;
        n_rnd   = r_rnd;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_start && !r_busy) begin
            n_state = i_block ^ i_key;
            n_rkey  = i_key;
            n_rc    = 8'h01;
            n_rnd   = 4'd1;
            n_busy  = 1'b1;
        end else if (r_busy) begin
            n_state = w_mix ^ w_key;
            n_rkey  = w_key;
            n_rc    = gf_dbl(r_rc);
            n_rnd   = r_rnd + 4'd1;
            if (r_rnd == LAST_RND) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_state <= n_state;
        r_rkey  <= n_rkey;
        r_rc    <= n_rc;
        r_rnd   <= n_rnd;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_busy   = r_busy;
    assign o_done   = r_done;
    assign o_result = r_state;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("done without a running block");
    a_no_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("done while busy");
    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rnd >= 4'd1 && r_rnd <= LAST_RND)) else $error("round out of range");

endmodule

[sv/ccm_telegram_tag_check.sv]
// ---------------------------------------------------------------------------
// ccm_telegram_tag_check: CCM 4-byte tag and counter check of a telegram
// Sequencer that chains B0, B1, optional B2 and A0 through one AES unit.
// ---------------------------------------------------------------------------
// One telegram is taken, then the block is busy until its result is handed
// over. Each AES-128 block runs in the shared round unit, B2 only for
// lengths 18 to 33; a length error skips the AES blocks. The next telegram
// is taken once the result transfer has happened.
module ccm_telegram_tag_check
    import cttc_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    cttc_stream_if.sink    i_in,
    cttc_stream_if.source  o_out
);

    t_state       r_state, n_state;
    t_in_item     r_item;
    logic [127:0] r_mac;
    t_out_item    r_res;
    logic         w_start, w_busy, w_done;
    logic [127:0] w_key, w_blk, w_b0, w_a0, w_b1, w_b2, w_res;
    logic [175:0] w_data;
    logic [7:0]   w_len3;
    logic         w_lerr, w_newer, w_in_ok;
    logic [31:0]  w_tag;

    assign w_key = {r_item.key_high, r_item.key_low};
    assign w_len3 = r_item.telegram_length - 8'd3;
    assign w_lerr = (r_item.telegram_length < LEN_MIN) || (r_item.telegram_length > LEN_MAX);
    assign w_newer = r_item.last_counter < r_item.sequence_counter;

    // Data bytes at or past length - 11 read as zero.
    always_comb begin
        w_data = {r_item.data_word2, r_item.data_word1, r_item.data_word0};
        for (int i = 0; i < 22; i++) begin
            if (8'(i) >= r_item.telegram_length - LEN_MIN) w_data[8*i +: 8] = 8'h00;
        end
    end

    // CCM blocks; byte 0 sits in bits 7:0.
    assign w_b0 = {40'h0, r_item.sequence_counter, r_item.sender_address, B0_FLAG};
    assign w_a0 = {40'h0, r_item.sequence_counter, r_item.sender_address, A0_FLAG};
    assign w_b1 = {w_data[47:0], r_item.sequence_counter, r_item.maker_id,
                   r_item.adv_type, r_item.telegram_length, w_len3, 8'h00};
    assign w_b2 = w_data[175:48];

    assign w_tag = r_mac[31:0] ^ w_res[31:0];

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_in.valid) n_state = ST_B0;
            ST_B0:   if (w_lerr) n_state = ST_DONE;
                     else if (w_done) n_state = ST_B1;
            ST_B1:   if (w_done)
                         n_state = (r_item.telegram_length > LEN_B2) ? ST_B2 : ST_A0;
            ST_B2:   if (w_done) n_state = ST_A0;
            ST_A0:   if (w_done) n_state = ST_DONE;
            ST_DONE: if (o_out.ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs to the AES unit.
    always_comb begin
        w_start = 1'b0;
        w_blk = w_b0;
        unique case (r_state)
            ST_B0:   begin w_start = !w_lerr && !w_busy && !w_done; w_blk = w_b0; end
            ST_B1:   begin w_start = !w_busy && !w_done; w_blk = r_mac ^ w_b1; end
            ST_B2:   begin w_start = !w_busy && !w_done; w_blk = r_mac ^ w_b2; end
            ST_A0:   begin w_start = !w_busy && !w_done; w_blk = w_a0; end
            default: begin w_start = 1'b0; w_blk = w_b0; end
        endcase
    end

    cttc_aes_round u_aes (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_key    (w_key),
        .i_block  (w_blk),
        .o_busy   (w_busy),
        .o_done   (w_done),
        .o_result (w_res)
    );

    assign i_in.ready  = (r_state == ST_IDLE);
    assign w_in_ok     = i_in.valid && i_in.ready;
    assign o_out.valid = (r_state == ST_DONE);
    assign o_out.data  = r_res;

    // Item capture, MAC chaining and result.
    always_ff @(posedge i_clk) begin
        if (w_in_ok) r_item <= i_in.data;
        if (w_done && r_state != ST_A0) r_mac <= w_res;
        if (r_state == ST_B0 && w_lerr) begin
            r_res <= '{accepted: 1'b0, tag_ok: 1'b0, counter_newer: w_newer,
                       length_error: 1'b1, computed_tag: 32'h0};
        end else if (r_state == ST_A0 && w_done) begin
            r_res <= '{accepted: (w_tag == r_item.signature) && w_newer,
                       tag_ok: w_tag == r_item.signature, counter_newer: w_newer,
                       length_error: 1'b0, computed_tag: w_tag};
        end
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> (o_out.valid && $stable(o_out.data)))
        else $error("result changed before transfer");
    a_idle_aes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !w_busy) else $error("AES busy while idle");
    a_accept_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.data.accepted |-> o_out.data.tag_ok && !o_out.data.length_error)
        else $error("accepted without a good tag");

endmodule

[tb/ccm_telegram_tag_check_tb.sv]
// ---------------------------------------------------------------------------
// ccm_telegram_tag_check_tb: self-checking bench of the telegram tag check
// Drives telegrams through the input channel, predicts each result with a
// local AES-128 CCM tag model or a typed verdict, and checks every transfer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ccm_telegram_tag_check_tb;
    import cttc_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int N_RANDOM       = 1830;

    logic i_clk;
    logic i_rst_n;

    cttc_stream_if #(.T(t_in_item))  tg_if ();
    cttc_stream_if #(.T(t_out_item)) res_if ();

    ccm_telegram_tag_check i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (tg_if.sink),
        .o_out   (res_if.source)
    );

    t_out_item verdict_q [$];
    int        fail_count = 0;
    int        idle_pct_src;
    int        idle_pct_snk;
    bit        hold_off;
    int        quiet_cycles = 0;

    // Substitution table used by the local cipher.
    byte unsigned sb [256] = '{
8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // One AES-128 block encryption; byte i of a block is bits 8*i+7:8*i.
    function automatic logic [127:0] aes_block(input logic [127:0] key, input logic [127:0] pt);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] k [16];
        logic [7:0] rc;
        logic [7:0] a0, a1, a2, a3, al;
        logic [127:0] ct;
        rc = 8'h01;
        for (int i = 0; i < 16; i++) begin
            k[i] = key[8*i +: 8];
            s[i] = pt[8*i +: 8] ^ k[i];
        end
        for (int rnd = 1; rnd <= 10; rnd++) begin
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    t[c*4+r] = sb[s[((c + r) & 3)*4 + r]];
            if (rnd < 10) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                    al = a0 ^ a1 ^ a2 ^ a3;
                    t[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
                    t[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
                    t[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
                    t[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
                end
            end
            k[0] = k[0] ^ sb[k[13]] ^ rc;
            k[1] = k[1] ^ sb[k[14]];
            k[2] = k[2] ^ sb[k[15]];
            k[3] = k[3] ^ sb[k[12]];
            for (int i = 4; i < 16; i++) k[i] = k[i] ^ k[i-4];
            rc = xtime(rc);
            for (int i = 0; i < 16; i++) s[i] = t[i] ^ k[i];
        end
        for (int i = 0; i < 16; i++) ct[8*i +: 8] = s[i];
        return ct;
    endfunction

    // Expected verdict of one telegram: CBC-MAC over B0, B1 and, for lengths above 17, B2, masked by S0.
    function automatic t_out_item telegram_verdict(input t_in_item tg);
        t_out_item    v;
        logic [127:0] key, b0, a0, b1, b2, x;
        logic [175:0] data;
        logic [7:0]   len;
        int           ndata;
        v   = '0;
        len = tg.telegram_length;
        key = {tg.key_high, tg.key_low};
        v.counter_newer = tg.sequence_counter > tg.last_counter;
        v.length_error  = (len < LEN_MIN) || (len > LEN_MAX);
        if (!v.length_error) begin
            ndata = int'(len) - 11;
            data  = {tg.data_word2, tg.data_word1, tg.data_word0};
            for (int i = 0; i < 22; i++)
                if (i >= ndata) data[8*i +: 8] = 8'h00;
            b0 = {40'h0, tg.sequence_counter, tg.sender_address, B0_FLAG};
            a0 = {40'h0, tg.sequence_counter, tg.sender_address, A0_FLAG};
            b1 = {data[47:0], tg.sequence_counter, tg.maker_id, tg.adv_type, len,
                  8'(len - 8'd3), 8'h00};
            b2 = data[175:48];
            x  = aes_block(key, b0);
            x  = aes_block(key, x ^ b1);
            if (len > LEN_B2) x = aes_block(key, x ^ b2);
            x  = x ^ aes_block(key, a0);
            v.computed_tag = x[31:0];
            v.tag_ok       = (x[31:0] == tg.signature);
            v.accepted     = v.tag_ok && v.counter_newer;
        end
        return v;
    endfunction

    // Telegram with random content; mostly valid lengths, some out of range.
    function automatic t_in_item rand_telegram();
        t_in_item tg;
        int       sel;
        tg.sender_address   = 48'({$urandom, $urandom});
        tg.key_low          = {$urandom, $urandom};
        tg.key_high         = {$urandom, $urandom};
        tg.sequence_counter = $urandom;
        tg.last_counter     = ($urandom_range(0, 3) == 0) ? $urandom
                              : tg.sequence_counter - 32'($urandom_range(0, 4)) + 32'd2;
        sel = $urandom_range(0, 19);
        tg.telegram_length  = (sel == 0) ? 8'($urandom) : 8'($urandom_range(11, 33));
        tg.adv_type         = 8'($urandom);
        tg.maker_id         = 16'($urandom);
        tg.data_word0       = {$urandom, $urandom};
        tg.data_word1       = {$urandom, $urandom};
        tg.data_word2       = 48'({$urandom, $urandom});
        tg.signature        = $urandom;
        return tg;
    endfunction

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Receiver side: random stalls, plus a long hold-off when requested.
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            res_if.ready <= !hold_off && ($urandom_range(0, 99) >= idle_pct_snk);
        end
    end

    // Result checker: compares each transfer with the oldest expectation.
    always @(posedge i_clk) begin
        t_out_item exp_v;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (verdict_q.size() == 0) begin
                $error("result transfer with no telegram pending");
                fail_count++;
            end else begin
                exp_v = verdict_q.pop_front();
                if (res_if.data.accepted !== exp_v.accepted) begin
                    $error("accepted: expected %0d actual %0d",
                           exp_v.accepted, res_if.data.accepted);
                    fail_count++;
                end
                if (res_if.data.tag_ok !== exp_v.tag_ok) begin
                    $error("tag_ok: expected %0d actual %0d", exp_v.tag_ok, res_if.data.tag_ok);
                    fail_count++;
                end
                if (res_if.data.counter_newer !== exp_v.counter_newer) begin
                    $error("counter_newer: expected %0d actual %0d",
                           exp_v.counter_newer, res_if.data.counter_newer);
                    fail_count++;
                end
                if (res_if.data.length_error !== exp_v.length_error) begin
                    $error("length_error: expected %0d actual %0d",
                           exp_v.length_error, res_if.data.length_error);
                    fail_count++;
                end
                if (res_if.data.computed_tag !== exp_v.computed_tag) begin
                    $error("computed_tag: expected %h actual %h",
                           exp_v.computed_tag, res_if.data.computed_tag);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if ((tg_if.valid && tg_if.ready) || (res_if.valid && res_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Send one telegram and record its expected verdict at the transfer.
    // Valid stays high after the transfer until the next call decides.
    task automatic send_telegram(input t_in_item tg, input bit typed, input t_out_item typed_v);
        while ($urandom_range(0, 99) < idle_pct_src) begin
            tg_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        tg_if.valid <= 1'b1;
        tg_if.data  <= tg;
        @(posedge i_clk);
        while (!tg_if.ready) @(posedge i_clk);
        verdict_q.push_back(typed ? typed_v : telegram_verdict(tg));
    endtask

    // Directed rows; verdict typed in only for length errors.
    typedef struct {
        t_in_item  tg;
        bit        typed;
        t_out_item v;
    } t_row;

    t_row rows [$];

    task automatic add_row(input t_in_item tg);
        t_row r;
        r.tg = tg;
        r.typed = 1'b0;
        r.v = '0;
        if (tg.telegram_length < LEN_MIN || tg.telegram_length > LEN_MAX) begin
            r.typed = 1'b1;
            r.v.length_error  = 1'b1;
            r.v.counter_newer = tg.sequence_counter > tg.last_counter;
        end
        rows.push_back(r);
    endtask

    task automatic build_rows();
        t_in_item base, tg;
        t_out_item v;
        base = '0;
        base.sequence_counter = 32'd5;
        base.last_counter     = 32'd4;
        base.telegram_length  = 8'd11;
        // Extremes of the length: all zero, all ones, bounds.
        add_row('0);
        tg = '1; add_row(tg);
        tg = '1; tg.telegram_length = 8'd10; add_row(tg);
        tg = '1; tg.telegram_length = 8'd34; tg.last_counter = '0; add_row(tg);
        tg = base; add_row(tg);
        tg = '1; tg.telegram_length = 8'd11; add_row(tg);
        tg = '1; tg.telegram_length = 8'd17; add_row(tg);
        tg = '1; tg.telegram_length = 8'd18; add_row(tg);
        tg = '1; tg.telegram_length = 8'd33; tg.last_counter = '0; add_row(tg);
        // Data beyond the length is ignored.
        tg = base; tg.telegram_length = 8'd20; tg.data_word2 = '1; add_row(tg);
        // Counter equal, older and wrapping.
        tg = base; tg.last_counter = 32'd5; add_row(tg);
        tg = base; tg.last_counter = '1; add_row(tg);
        tg = base; tg.sequence_counter = '1; tg.last_counter = 32'hffff_fffe; add_row(tg);
        // Correct signatures so that accepted goes high, and one bit wrong.
        for (int i = 0; i < 4; i++) begin
            tg = rand_telegram();
            tg.telegram_length = 8'd11 + 8'(i * 7);
            tg.last_counter = tg.sequence_counter - 32'd1;
            if (tg.sequence_counter == 0) tg.sequence_counter = 32'd1;
            tg.last_counter = tg.sequence_counter - 32'd1;
            v = telegram_verdict(tg);
            tg.signature = v.computed_tag ^ ((i == 3) ? 32'h0000_0100 : 32'h0);
            add_row(tg);
        end
    endtask

    initial begin
        t_in_item  tg;
        t_out_item v_chk;
        hold_off     = 1'b0;
        idle_pct_src = 0;
        idle_pct_snk = 0;
        tg_if.valid  = 1'b0;
        tg_if.data   = '0;
        i_rst_n      = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        build_rows();
        foreach (rows[i]) send_telegram(rows[i].tg, rows[i].typed, rows[i].v);

        // Random telegrams over the idling phases; one long receiver hold-off.
        for (int ph = 0; ph < 4; ph++) begin
            unique case (ph)
                0: begin idle_pct_src = 0;  idle_pct_snk = 0;  end
                1: begin idle_pct_src = 83; idle_pct_snk = 0;  end
                2: begin idle_pct_src = 0;  idle_pct_snk = 83; end
                default: begin idle_pct_src = 6; idle_pct_snk = 6; end
            endcase
            if (ph == 0) begin
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (400) @(posedge i_clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            for (int k = 0; k < N_RANDOM / 4; k++) begin
                tg = rand_telegram();
                if ($urandom_range(0, 4) == 0) begin
                    v_chk = telegram_verdict(tg);
                    tg.signature = v_chk.computed_tag;
                end
                send_telegram(tg, 1'b0, '0);
            end
        end
        tg_if.valid <= 1'b0;

        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[sim.f]
sv/cttc_pkg.sv
sv/cttc_stream_if.sv
sv/cttc_aes_round.sv
sv/ccm_telegram_tag_check.sv
tb/ccm_telegram_tag_check_tb.sv
